/* design/circ_dq_pkg.sv */
// shared constants, types and action codes for the circular deque
package circ_dq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int ACT_W  = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ_FRONT = 3'd4,
    ACT_READ_REAR  = 3'd5
  } action_t;

  localparam cnt_t CAP_RESET = cnt_t'(DEPTH);

  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    idx_t  addr;
    word_t wdata;
  } mem_op_t;

  typedef struct packed {
    logic ok;
    logic is_empty;
    logic is_full;
    logic use_mem;
    logic neg_one;
  } rsp_ctl_t;

endpackage

/* design/circ_dq_ifs.sv */
// request and response channel interfaces of the circular deque
interface circ_dq_req_if import circ_dq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface circ_dq_rsp_if import circ_dq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [WORD_W-1:0] data;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, ok, data, is_empty, is_full, input ready);
  modport sink (input valid, ok, data, is_empty, is_full, output ready);
endinterface

/* design/circ_dq_ram.sv */
// ring store: one write or one registered read per cycle
module circ_dq_ram
  import circ_dq_pkg::*;
(
  input  logic    clk,
  input  mem_op_t op,
  output word_t   rd_data
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[op.addr] <= op.wdata;
    end
    if (op.rd_en) begin
      rd_data <= mem[op.addr];
    end
  end

endmodule

/* design/circ_dq_ctrl.sv */
// index, count and capacity state with per-request decode
module circ_dq_ctrl
  import circ_dq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  input  logic               accept,
  input  logic [ACT_W-1:0]   action,
  input  word_t              value,
  output mem_op_t            op,
  output rsp_ctl_t           ctl
);

  idx_t front, front_next;
  idx_t back, back_next;
  cnt_t count, count_next;
  cnt_t cap;
  cnt_t cap_clamped;

  logic empty, full;
  idx_t front_prev, front_succ, back_prev, back_succ;
  idx_t cap_last;

  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_clamped = cnt_t'(1);
    end else if (cfg_wr_data > CAP_RESET) begin
      cap_clamped = CAP_RESET;
    end else begin
      cap_clamped = cfg_wr_data;
    end
  end

  assign empty    = (count == '0);
  assign full     = (count >= cap);
  assign cap_last = idx_t'(cap - cnt_t'(1));

  assign front_prev = (front == '0 || cnt_t'(front) >= cap) ? cap_last : front - idx_t'(1);
  assign back_prev  = (back == '0 || cnt_t'(back) >= cap) ? cap_last : back - idx_t'(1);
  assign front_succ = (cnt_t'(front) + cnt_t'(1) >= cap) ? '0 : front + idx_t'(1);
  assign back_succ  = (cnt_t'(back) + cnt_t'(1) >= cap) ? '0 : back + idx_t'(1);

  always_comb begin
    front_next  = front;
    back_next   = back;
    count_next  = count;
    op.wr_en    = 1'b0;
    op.rd_en    = 1'b0;
    op.addr     = front;
    op.wdata    = value;
    ctl.ok      = 1'b0;
    ctl.use_mem = 1'b0;
    ctl.neg_one = 1'b0;
    case (action)
      ACT_PUSH_FRONT: begin
        if (!full) begin
          front_next = front_prev;
          op.addr    = front_prev;
          op.wr_en   = accept;
          count_next = count + cnt_t'(1);
          ctl.ok     = 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (!full) begin
          back_next  = back_succ;
          op.addr    = back_succ;
          op.wr_en   = accept;
          count_next = count + cnt_t'(1);
          ctl.ok     = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty) begin
          front_next = front_succ;
          count_next = count - cnt_t'(1);
          ctl.ok     = 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (!empty) begin
          back_next  = back_prev;
          count_next = count - cnt_t'(1);
          ctl.ok     = 1'b1;
        end
      end
      ACT_READ_FRONT: begin
        if (empty) begin
          ctl.neg_one = 1'b1;
        end else begin
          op.addr     = front;
          op.rd_en    = accept;
          ctl.use_mem = 1'b1;
          ctl.ok      = 1'b1;
        end
      end
      ACT_READ_REAR: begin
        if (empty) begin
          ctl.neg_one = 1'b1;
        end else begin
          op.addr     = back;
          op.rd_en    = accept;
          ctl.use_mem = 1'b1;
          ctl.ok      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ctl.is_empty = (count_next == '0);
    ctl.is_full  = (count_next >= cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RESET;
      front <= '0;
      back  <= idx_t'(CAP_RESET - cnt_t'(1));
      count <= '0;
    end else if (cfg_wr_en) begin
      cap   <= cap_clamped;
      front <= '0;
      back  <= idx_t'(cap_clamped - cnt_t'(1));
      count <= '0;
    end else if (accept) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

endmodule

/* design/circ_dq_out.sv */
// result stage and output register with flow control
module circ_dq_out
  import circ_dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rsp_ctl_t ctl,
  input  word_t    rd_data,
  circ_dq_rsp_if.source rsp
);

  logic     advance;
  logic     accept;
  logic     s1_valid;
  rsp_ctl_t s1_ctl;
  word_t    data_next;

  assign advance  = !rsp.valid || rsp.ready;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (s1_ctl.use_mem) begin
      data_next = rd_data;
    end else if (s1_ctl.neg_one) begin
      data_next = '1;
    end else begin
      data_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
    end
    if (s1_valid && advance) begin
      rsp.ok       <= s1_ctl.ok;
      rsp.is_empty <= s1_ctl.is_empty;
      rsp.is_full  <= s1_ctl.is_full;
      rsp.data     <= data_next;
    end
  end

endmodule

/* design/circular_deque.sv */
// circular deque top level
// Bounded double-ended queue of signed 32-bit words in a 64-slot ring store.
// One request transaction is taken per cycle as long as responses are taken.
// The state update, store access and response stage register are loaded when
// a request is taken, and the output register follows from the response stage.
// The store is a single-port memory with a registered read, used
// for either the write of a push or the read of a front/rear read. Writing
// capacity (0 acts as 1, above 64 acts as 64) empties the deque; write it only
// while no request is in flight.
module circular_deque
  import circ_dq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data,
  circ_dq_req_if.sink        req,
  circ_dq_rsp_if.source      rsp
);

  logic     accept;
  mem_op_t  op;
  rsp_ctl_t ctl;
  word_t    rd_data;

  assign accept = req.valid && req.ready;

  circ_dq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .action      (req.action),
    .value       (req.value),
    .op          (op),
    .ctl         (ctl)
  );

  circ_dq_ram u_ram (
    .clk     (clk),
    .op      (op),
    .rd_data (rd_data)
  );

  circ_dq_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .ctl      (ctl),
    .rd_data  (rd_data),
    .rsp      (rsp)
  );

endmodule

/* tb/circular_deque_test.sv */
// testbench for the circular deque: random and directed requests checked against a predictor
module circular_deque_test import circ_dq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ACT_W-1:0] action;
    word_t            value;
  } dq_request_t;

  typedef struct {
    logic  ok;
    word_t data;
    logic  is_empty;
    logic  is_full;
  } dq_response_t;

  localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;
  localparam int HOLD_CYCLES = 200;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  cnt_t       cfg_wr_data;

  circ_dq_req_if req_ch();
  circ_dq_rsp_if rsp_ch();

  circular_deque dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  dq_request_t  pending_requests[$];
  dq_response_t expected_responses[$];
  int           queued_count = 0;
  int           accepted_count = 0;
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         req_taken = 1'b0;
  logic         hold_rsp = 1'b0;
  event         stall_go;

  word_t dq_slots [DEPTH];
  idx_t  dq_front;
  idx_t  dq_back;
  cnt_t  dq_count;
  cnt_t  dq_cap;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic idx_t slot_after(idx_t i);
    return (int'(i) + 1 >= int'(dq_cap)) ? idx_t'(0) : idx_t'(i + 1);
  endfunction

  function automatic idx_t slot_before(idx_t i);
    return (i == 0 || int'(i) >= int'(dq_cap)) ? idx_t'(dq_cap - 1) : idx_t'(i - 1);
  endfunction

  function automatic void set_capacity(cnt_t raw);
    cnt_t c;
    c = raw;
    if (c == 0) c = cnt_t'(1);
    if (c > cnt_t'(DEPTH)) c = cnt_t'(DEPTH);
    dq_cap = c;
    dq_front = '0;
    dq_back = idx_t'(c - 1);
    dq_count = '0;
  endfunction

  function automatic dq_response_t deque_response(dq_request_t r);
    dq_response_t res;
    logic was_empty;
    logic was_full;
    was_empty = (dq_count == 0);
    was_full = (dq_count >= dq_cap);
    res.ok = 1'b0;
    res.data = '0;
    case (r.action)
      ACT_PUSH_FRONT: if (!was_full) begin
        dq_front = slot_before(dq_front);
        dq_slots[dq_front] = r.value;
        dq_count++;
        res.ok = 1'b1;
      end
      ACT_PUSH_BACK: if (!was_full) begin
        dq_back = slot_after(dq_back);
        dq_slots[dq_back] = r.value;
        dq_count++;
        res.ok = 1'b1;
      end
      ACT_POP_FRONT: if (!was_empty) begin
        dq_front = slot_after(dq_front);
        dq_count--;
        res.ok = 1'b1;
      end
      ACT_POP_BACK: if (!was_empty) begin
        dq_back = slot_before(dq_back);
        dq_count--;
        res.ok = 1'b1;
      end
      ACT_READ_FRONT: if (was_empty) begin
        res.data = -1;
      end else begin
        res.data = dq_slots[dq_front];
        res.ok = 1'b1;
      end
      ACT_READ_REAR: if (was_empty) begin
        res.data = -1;
      end else begin
        res.data = dq_slots[dq_back];
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.is_empty = (dq_count == 0);
    res.is_full = (dq_count >= dq_cap);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < 200)
      $display("mismatch in %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // request driver
  always @(negedge clk) begin
    dq_request_t next_req;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= next_req.action;
        req_ch.value <= next_req.value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(stall_go) begin
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // response monitor, then prediction of the transaction taken at this edge
  always @(posedge clk) begin
    dq_response_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected response", rsp_ch.data, '0);
        end else begin
          want = expected_responses.pop_front();
          if (rsp_ch.ok !== want.ok) report_mismatch("ok", rsp_ch.ok, want.ok);
          if (rsp_ch.data !== want.data) report_mismatch("data", rsp_ch.data, want.data);
          if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", rsp_ch.is_empty, want.is_empty);
          if (rsp_ch.is_full !== want.is_full)
            report_mismatch("is_full", rsp_ch.is_full, want.is_full);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_responses.insert(expected_responses.size(),
          deque_response('{action: req_ch.action, value: req_ch.value}));
        accepted_count++;
      end
    end
  end

  task automatic queue_request(logic [ACT_W-1:0] act, word_t val);
    pending_requests.insert(pending_requests.size(), '{action: act, value: val});
    queued_count++;
  endtask

  task automatic queue_random(int n, int push_pct, int pop_pct);
    int r;
    word_t v;
    logic [ACT_W-1:0] act;
    repeat (n) begin
      case ($urandom_range(9))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = '0;
        3: v = '1;
        default: v = $urandom;
      endcase
      r = $urandom_range(99);
      if (r < 3) act = $urandom_range(1) ? ACT_BAD_HI : ACT_BAD_LO;
      else if (r < 3 + push_pct) act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else if (r < 3 + push_pct + pop_pct) act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
      else act = $urandom_range(1) ? ACT_READ_REAR : ACT_READ_FRONT;
      queue_request(act, v);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_responses.size() != 0);
  endtask

  task automatic write_capacity(cnt_t v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    set_capacity(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(cnt_t cap, int s_pct, int r_pct, int n, int push_pct, int pop_pct);
    write_capacity(cap);
    @(posedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    queue_random(n, push_pct, pop_pct);
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    set_capacity(CAP_RESET);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity
    @(posedge clk);
    send_idle_pct = 19;
    recv_idle_pct = 80;
    queue_request(ACT_READ_REAR, 32'sd7);
    queue_request(ACT_PUSH_FRONT, 32'sd12345);
    queue_request(ACT_READ_REAR, 32'sd0);
    queue_request(ACT_POP_BACK, 32'sd0);

    write_capacity(7'd2);
    @(posedge clk);
    queue_request(ACT_READ_FRONT, 32'sd0);
    queue_request(ACT_READ_REAR, 32'sd0);
    queue_request(ACT_POP_FRONT, 32'sd0);
    queue_request(ACT_POP_BACK, 32'sd0);
    queue_request(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    queue_request(ACT_PUSH_BACK, 32'sh8000_0000);
    queue_request(ACT_PUSH_FRONT, 32'sd1);
    queue_request(ACT_PUSH_BACK, 32'sd2);
    queue_request(ACT_READ_FRONT, 32'sd0);
    queue_request(ACT_READ_REAR, 32'sd0);
    queue_request(ACT_BAD_LO, 32'sd3);
    queue_request(ACT_POP_FRONT, 32'sd0);
    queue_request(ACT_READ_FRONT, 32'sd0);
    queue_request(ACT_POP_BACK, 32'sd0);
    queue_request(ACT_BAD_HI, 32'sd4);
    queue_request(ACT_PUSH_BACK, -32'sd1);

    // zero capacity behaves as one slot
    write_capacity(7'd0);
    @(posedge clk);
    queue_request(ACT_PUSH_FRONT, 32'sd0);
    queue_request(ACT_PUSH_BACK, 32'sd5);
    queue_request(ACT_READ_REAR, 32'sd0);
    queue_request(ACT_POP_BACK, 32'sd0);

    run_phase(7'd5, 19, 80, 100, 40, 35);
    run_phase(7'd127, 19, 80, 120, 70, 10);
    queue_random(80, 10, 70);
    run_phase(7'd1, 80, 19, 60, 40, 35);
    run_phase(7'd7, 80, 19, 100, 45, 30);

    // receiver holds off while the sender keeps offering
    write_capacity(7'd64);
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(120, 50, 30);
    -> stall_go;
    run_phase(7'd3, 0, 0, 60, 40, 35);

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("circular_deque_test OK");
    end else begin
      $display("circular_deque_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("circular_deque_test NOT OK");
    $finish;
  end

endmodule
